[hw/rtl/bcg_pkg.sv]
package bcg_pkg;

  localparam int unsigned PULSES_PER_QUARTER_DEF = 96;
  localparam int unsigned MAX_BEATS_DEF          = 16;
  localparam int unsigned TICK_WIDTH_DEF         = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned RUN_W      = 2;
  localparam int unsigned BPB_W      = 5;
  localparam int unsigned UNIT_W     = 6;
  localparam int unsigned CHAN_W     = 4;
  localparam int unsigned CLICK_W    = 14;
  localparam int unsigned BARS_W     = 8;
  localparam int unsigned NOTE_W     = 7;
  localparam int unsigned STATUS_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEATS_PER_BAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_UNIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCENT_CLICK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REGULAR_CLICK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_BARS     = 3'd6;

  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

  localparam logic [RUN_W-1:0] RUN_OFF  = 2'd0;
  localparam logic [RUN_W-1:0] RUN_MIDI = 2'd2;

  localparam logic [UNIT_W-1:0] UNIT_EIGHTH = 6'd8;
  localparam logic [UNIT_W-1:0] UNIT_HALF   = 6'd2;

  localparam logic [RUN_W-1:0]   RST_RUN_MODE      = 2'd0;
  localparam logic [BPB_W-1:0]   RST_BEATS_PER_BAR = 5'd4;
  localparam logic [UNIT_W-1:0]  RST_BEAT_UNIT     = 6'd4;
  localparam logic [CHAN_W-1:0]  RST_CHANNEL       = 4'd9;
  localparam logic [CLICK_W-1:0] RST_ACCENT_CLICK  = 14'd9828;
  localparam logic [CLICK_W-1:0] RST_REGULAR_CLICK = 14'd9936;
  localparam logic [BARS_W-1:0]  RST_LEAD_BARS     = 8'd0;

  localparam logic [STATUS_W-1:0] NOTE_ON_STATUS = 8'h90;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIV1   = 4'b0010,
    ST_DIV2   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

endpackage

[hw/rtl/bcg_div.sv]
module bcg_div #(
  parameter int unsigned DIV_W = 32,
  parameter int unsigned DVS_W = 12,
  parameter int unsigned CNT_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] steps_i,
  output logic             done_o,
  output logic [DVS_W-1:0] rem_o
);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   trial;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = DVS_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/beat_click_generator_unit.sv]
// Channel  Direction  Handshake                Payload
// input    in         in_valid_i / in_stall_o   mode_i, tick_count_i, playing_i
// output   out        out_valid_o / out_stall_i click_o, accent_o, status_byte_o, note_o,
//                                               velocity_o, count_in_on_o
// config   in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A tick transaction that does work runs the bit-serial remainder unit twice, first for the
// position in the bar and then for the position in the beat. Commands and idle ticks
// skip the remainder unit and go straight to the result. One transaction is in flight at a time.
// The finished result sits in an output register, so the next transaction is accepted
// while a result is stalled; it waits before its own result only if that one is still held.
// Reset is asynchronous and active low and loads the documented register defaults.
module beat_click_generator_unit #(
  parameter int unsigned PULSES_PER_QUARTER = bcg_pkg::PULSES_PER_QUARTER_DEF,
  parameter int unsigned MAX_BEATS          = bcg_pkg::MAX_BEATS_DEF,
  parameter int unsigned TICK_WIDTH         = bcg_pkg::TICK_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bcg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bcg_pkg::MODE_W-1:0]          mode_i,
  input  logic [TICK_WIDTH-1:0]               tick_count_i,
  input  logic                                playing_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                click_o,
  output logic                                accent_o,
  output logic [bcg_pkg::STATUS_W-1:0]        status_byte_o,
  output logic [bcg_pkg::NOTE_W-1:0]          note_o,
  output logic [bcg_pkg::NOTE_W-1:0]          velocity_o,
  output logic                                count_in_on_o
);

  localparam int unsigned BAR_W   = $clog2(2 * PULSES_PER_QUARTER * MAX_BEATS + 1);
  localparam int unsigned BEATS_W = $clog2(MAX_BEATS + 1);
  localparam int unsigned DIV_W   = (TICK_WIDTH > BAR_W) ? TICK_WIDTH : BAR_W;
  localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
  localparam int unsigned LIM_W   = bcg_pkg::BARS_W + BAR_W;
  localparam int unsigned CMP_W   = (TICK_WIDTH > LIM_W) ? TICK_WIDTH : LIM_W;
  localparam int unsigned ALIGN   = DIV_W - BAR_W;

  localparam logic [BAR_W-1:0] TPB_QUARTER = BAR_W'(PULSES_PER_QUARTER);
  localparam logic [BAR_W-1:0] TPB_EIGHTH  = BAR_W'(PULSES_PER_QUARTER / 2);
  localparam logic [BAR_W-1:0] TPB_HALF    = BAR_W'(PULSES_PER_QUARTER * 2);

  logic [bcg_pkg::RUN_W-1:0]   run_mode_q;
  logic [bcg_pkg::BPB_W-1:0]   beats_per_bar_q;
  logic [bcg_pkg::UNIT_W-1:0]  beat_unit_q;
  logic [bcg_pkg::CHAN_W-1:0]  channel_q;
  logic [bcg_pkg::CLICK_W-1:0] accent_click_q;
  logic [bcg_pkg::CLICK_W-1:0] regular_click_q;
  logic [bcg_pkg::BARS_W-1:0]  lead_bars_q;

  bcg_pkg::state_e state_q;

  logic [bcg_pkg::MODE_W-1:0] mode_q;
  logic [TICK_WIDTH-1:0]      tick_q;
  logic                       work_q;
  logic [BAR_W-1:0]           tpb_q;
  logic [BAR_W-1:0]           bar_len_q;
  logic [BAR_W-1:0]           in_bar_q;
  logic [BAR_W-1:0]           start_q;
  logic [LIM_W-1:0]           limit_q;

  logic [BAR_W-1:0]           last_beat_start_q;
  logic                       last_beat_valid_q;
  logic                       count_in_flag_q;

  logic                       out_valid_q;
  logic                       click_q;
  logic                       accent_q;
  logic [bcg_pkg::STATUS_W-1:0] status_q;
  logic [bcg_pkg::NOTE_W-1:0] note_q;
  logic [bcg_pkg::NOTE_W-1:0] velocity_q;

  logic                       in_accept;
  logic                       out_free;
  logic [BAR_W-1:0]           tpb;
  logic [7:0]                 bpb_ext;
  logic [BEATS_W-1:0]         beats;
  logic [BAR_W-1:0]           bar_len;
  logic                       work;

  logic                       div_start;
  logic [DIV_W-1:0]           div_dividend;
  logic [BAR_W-1:0]           div_divisor;
  logic [CNT_W-1:0]           div_steps;
  logic                       div_done;
  logic [BAR_W-1:0]           div_rem;

  logic                       new_beat;
  logic                       downbeat;
  logic [bcg_pkg::CLICK_W-1:0] sel_click;
  logic                       count_in_end;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != bcg_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (beat_unit_q == bcg_pkg::UNIT_EIGHTH) begin
      tpb = TPB_EIGHTH;
    end else if (beat_unit_q == bcg_pkg::UNIT_HALF) begin
      tpb = TPB_HALF;
    end else begin
      tpb = TPB_QUARTER;
    end
    bpb_ext = 8'(beats_per_bar_q);
    if (bpb_ext == 8'd0) begin
      beats = BEATS_W'(1);
    end else if (bpb_ext > 8'(MAX_BEATS)) begin
      beats = BEATS_W'(MAX_BEATS);
    end else begin
      beats = BEATS_W'(bpb_ext);
    end
    bar_len = BAR_W'(tpb * beats);
    work = (mode_i == bcg_pkg::MODE_TICK) && (run_mode_q != bcg_pkg::RUN_OFF) &&
           (playing_i || count_in_flag_q);
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(tick_count_i);
    div_divisor  = bar_len;
    div_steps    = CNT_W'(DIV_W);
    if (state_q == bcg_pkg::ST_IDLE) begin
      div_start = in_accept && work;
    end else if (state_q == bcg_pkg::ST_DIV1) begin
      div_start    = div_done;
      div_dividend = DIV_W'(div_rem) << ALIGN;
      div_divisor  = tpb_q;
      div_steps    = CNT_W'(BAR_W);
    end
  end

  bcg_div #(
    .DIV_W(DIV_W),
    .DVS_W(BAR_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .steps_i   (div_steps),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    new_beat     = work_q && (!last_beat_valid_q || (start_q != last_beat_start_q));
    downbeat     = (start_q == '0);
    sel_click    = downbeat ? accent_click_q : regular_click_q;
    count_in_end = count_in_flag_q && (lead_bars_q != '0) &&
                   (CMP_W'(tick_q) >= CMP_W'(limit_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q      <= bcg_pkg::RST_RUN_MODE;
      beats_per_bar_q <= bcg_pkg::RST_BEATS_PER_BAR;
      beat_unit_q     <= bcg_pkg::RST_BEAT_UNIT;
      channel_q       <= bcg_pkg::RST_CHANNEL;
      accent_click_q  <= bcg_pkg::RST_ACCENT_CLICK;
      regular_click_q <= bcg_pkg::RST_REGULAR_CLICK;
      lead_bars_q     <= bcg_pkg::RST_LEAD_BARS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcg_pkg::CFG_RUN_MODE:      run_mode_q      <= cfg_data_i[bcg_pkg::RUN_W-1:0];
        bcg_pkg::CFG_BEATS_PER_BAR: beats_per_bar_q <= cfg_data_i[bcg_pkg::BPB_W-1:0];
        bcg_pkg::CFG_BEAT_UNIT:     beat_unit_q     <= cfg_data_i[bcg_pkg::UNIT_W-1:0];
        bcg_pkg::CFG_CHANNEL:       channel_q       <= cfg_data_i[bcg_pkg::CHAN_W-1:0];
        bcg_pkg::CFG_ACCENT_CLICK:  accent_click_q  <= cfg_data_i[bcg_pkg::CLICK_W-1:0];
        bcg_pkg::CFG_REGULAR_CLICK: regular_click_q <= cfg_data_i[bcg_pkg::CLICK_W-1:0];
        bcg_pkg::CFG_LEAD_BARS:     lead_bars_q     <= cfg_data_i[bcg_pkg::BARS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= bcg_pkg::ST_IDLE;
      last_beat_start_q <= '0;
      last_beat_valid_q <= 1'b0;
      count_in_flag_q   <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != bcg_pkg::ST_RESULT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        bcg_pkg::ST_IDLE: begin
          if (in_accept) begin
            state_q <= work ? bcg_pkg::ST_DIV1 : bcg_pkg::ST_RESULT;
          end
        end
        bcg_pkg::ST_DIV1: begin
          if (div_done) begin
            state_q <= bcg_pkg::ST_DIV2;
          end
        end
        bcg_pkg::ST_DIV2: begin
          if (div_done) begin
            state_q <= bcg_pkg::ST_RESULT;
          end
        end
        bcg_pkg::ST_RESULT: begin
          if (out_free) begin
            state_q     <= bcg_pkg::ST_IDLE;
            out_valid_q <= 1'b1;
            if (mode_q == bcg_pkg::MODE_TICK) begin
              if (new_beat) begin
                last_beat_start_q <= start_q;
                last_beat_valid_q <= 1'b1;
                if (count_in_end) begin
                  count_in_flag_q <= 1'b0;
                end
              end
            end else if (mode_q == bcg_pkg::MODE_START) begin
              if (lead_bars_q != '0) begin
                count_in_flag_q   <= 1'b1;
                last_beat_valid_q <= 1'b0;
              end
            end else if (mode_q == bcg_pkg::MODE_CANCEL) begin
              count_in_flag_q <= 1'b0;
            end
          end
        end
        default: state_q <= bcg_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q    <= mode_i;
      tick_q    <= tick_count_i;
      work_q    <= work;
      tpb_q     <= tpb;
      bar_len_q <= bar_len;
    end
    if (state_q == bcg_pkg::ST_DIV1 && div_done) begin
      in_bar_q <= div_rem;
    end
    if (state_q == bcg_pkg::ST_DIV2 && div_done) begin
      start_q <= in_bar_q - div_rem;
      limit_q <= LIM_W'(lead_bars_q) * LIM_W'(bar_len_q);
    end
    if (state_q == bcg_pkg::ST_RESULT && out_free) begin
      status_q <= bcg_pkg::NOTE_ON_STATUS | bcg_pkg::STATUS_W'(channel_q);
      if (new_beat && run_mode_q == bcg_pkg::RUN_MIDI) begin
        click_q    <= 1'b1;
        accent_q   <= downbeat;
        note_q     <= sel_click[13:7];
        velocity_q <= sel_click[6:0];
      end else begin
        click_q    <= 1'b0;
        accent_q   <= 1'b0;
        note_q     <= '0;
        velocity_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign click_o       = click_q;
  assign accent_o      = accent_q;
  assign status_byte_o = status_q;
  assign note_o        = note_q;
  assign velocity_o    = velocity_q;
  assign count_in_on_o = count_in_flag_q;

endmodule

[test/tb_beat_click_generator_unit.sv]
module tb_beat_click_generator_unit;
  import bcg_pkg::*;

  localparam int unsigned PPQ      = PULSES_PER_QUARTER_DEF;
  localparam int unsigned BEAT_CAP = MAX_BEATS_DEF;
  localparam int unsigned TW       = TICK_WIDTH_DEF;

  // Codes that the package leaves unnamed but that the fields allow.
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;
  localparam logic [RUN_W-1:0]  RUN_SPARE  = 2'd3;

  localparam int RANDOM_ITEMS  = 400;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic                click;
    logic                accent;
    logic [STATUS_W-1:0] status;
    logic [NOTE_W-1:0]   note;
    logic [NOTE_W-1:0]   velocity;
    logic                count_in;
  } click_t;

  class click_scoreboard;
    logic [RUN_W-1:0]   run_mode;
    logic [BPB_W-1:0]   beats_per_bar;
    logic [UNIT_W-1:0]  beat_unit;
    logic [CHAN_W-1:0]  channel;
    logic [CLICK_W-1:0] accent_click;
    logic [CLICK_W-1:0] regular_click;
    logic [BARS_W-1:0]  lead_bars;
    logic [11:0]        beat_start;
    bit                 beat_known;
    bit                 count_in;
    click_t             pending_clicks[$];
    int                 mismatches;
    int                 results_checked;
    int                 clicks_seen;
    int                 count_in_ends;

    function new();
      run_mode        = RST_RUN_MODE;
      beats_per_bar   = RST_BEATS_PER_BAR;
      beat_unit       = RST_BEAT_UNIT;
      channel         = RST_CHANNEL;
      accent_click    = RST_ACCENT_CLICK;
      regular_click   = RST_REGULAR_CLICK;
      lead_bars       = RST_LEAD_BARS;
      beat_start      = '0;
      beat_known      = 1'b0;
      count_in        = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      clicks_seen     = 0;
      count_in_ends   = 0;
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %0d at %0t, result %0d: %s got 0x%0h, want 0x%0h",
               mismatches, $time, results_checked, what, got, want);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RUN_MODE:      run_mode      = data[RUN_W-1:0];
        CFG_BEATS_PER_BAR: beats_per_bar = data[BPB_W-1:0];
        CFG_BEAT_UNIT:     beat_unit     = data[UNIT_W-1:0];
        CFG_CHANNEL:       channel       = data[CHAN_W-1:0];
        CFG_ACCENT_CLICK:  accent_click  = data[CLICK_W-1:0];
        CFG_REGULAR_CLICK: regular_click = data[CLICK_W-1:0];
        CFG_LEAD_BARS:     lead_bars     = data[BARS_W-1:0];
        default: ;
      endcase
    endfunction

    function void predict_click(logic [MODE_W-1:0] m, logic [TW-1:0] t, logic p);
      click_t             want;
      longint unsigned    tick;
      longint unsigned    tpb;
      longint unsigned    beats;
      longint unsigned    bar_len;
      longint unsigned    beat;
      longint unsigned    start;
      logic [CLICK_W-1:0] sound;
      want = '0;
      tick = t;
      if (m == MODE_TICK) begin
        if (run_mode != RUN_OFF && (p || count_in)) begin
          tpb = PPQ;
          if (beat_unit == UNIT_EIGHTH) begin
            tpb = PPQ / 2;
          end else if (beat_unit == UNIT_HALF) begin
            tpb = PPQ * 2;
          end
          beats = beats_per_bar;
          if (beats == 0) begin
            beats = 1;
          end else if (beats > BEAT_CAP) begin
            beats = BEAT_CAP;
          end
          bar_len = tpb * beats;
          beat    = (tick % bar_len) / tpb;
          start   = beat * tpb;
          if (!beat_known || start != beat_start) begin
            beat_start = start[11:0];
            beat_known = 1'b1;
            if (run_mode == RUN_MIDI) begin
              sound         = (beat == 0) ? accent_click : regular_click;
              want.click    = 1'b1;
              want.accent   = (beat == 0);
              want.note     = sound[13:7];
              want.velocity = sound[6:0];
              clicks_seen++;
            end
            if (count_in && lead_bars != 0 && tick >= lead_bars * bar_len) begin
              count_in = 1'b0;
              count_in_ends++;
            end
          end
        end
      end else if (m == MODE_START) begin
        if (lead_bars != 0) begin
          count_in   = 1'b1;
          beat_known = 1'b0;
        end
      end else if (m == MODE_CANCEL) begin
        count_in = 1'b0;
      end
      want.status   = NOTE_ON_STATUS | {4'b0, channel};
      want.count_in = count_in;
      pending_clicks.push_back(want);
    endfunction

    task check_click(click_t got);
      click_t want;
      if (pending_clicks.size() == 0) begin
        report("result with nothing pending", got, 0);
      end else begin
        want = pending_clicks.pop_front();
        results_checked++;
        if (got.click !== want.click) report("click", got.click, want.click);
        if (got.accent !== want.accent) report("accent", got.accent, want.accent);
        if (got.status !== want.status) report("status_byte", got.status, want.status);
        if (got.note !== want.note) report("note", got.note, want.note);
        if (got.velocity !== want.velocity) report("velocity", got.velocity, want.velocity);
        if (got.count_in !== want.count_in) report("count_in_on", got.count_in, want.count_in);
      end
    endtask

    task flush_check();
      click_t want;
      while (pending_clicks.size() != 0) begin
        want = pending_clicks.pop_front();
        report("missing result", 0, want);
      end
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [MODE_W-1:0]     mode_i        = '0;
  logic [TW-1:0]         tick_count_i  = '0;
  logic                  playing_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  click_o;
  logic                  accent_o;
  logic [STATUS_W-1:0]   status_byte_o;
  logic [NOTE_W-1:0]     note_o;
  logic [NOTE_W-1:0]     velocity_o;
  logic                  count_in_on_o;

  click_scoreboard sb = new();

  int items_sent  = 0;
  int burst_left  = 0;
  int gap_max     = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int stall_pct   = 0;
  int pattern_age = 0;
  click_t got;

  beat_click_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .tick_count_i  (tick_count_i),
    .playing_i     (playing_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .click_o       (click_o),
    .accent_o      (accent_o),
    .status_byte_o (status_byte_o),
    .note_o        (note_o),
    .velocity_o    (velocity_o),
    .count_in_on_o (count_in_on_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(50, 300);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 50;
      endcase
    end
    pattern_age--;
    if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 16);
    end
    out_stall_i <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {click_o, accent_o, status_byte_o, note_o, velocity_o, count_in_on_o};
      sb.check_click(got);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [TW-1:0] t, input logic p);
    int gap;
    mode_i       <= m;
    tick_count_i <= t;
    playing_i    <= p;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.predict_click(m, t, p);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 10);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_clicks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [RUN_W-1:0] run, input logic [BPB_W-1:0] bpb,
                              input logic [UNIT_W-1:0] unit, input logic [CHAN_W-1:0] chan,
                              input logic [CLICK_W-1:0] acc, input logic [CLICK_W-1:0] reg_snd,
                              input logic [BARS_W-1:0] bars);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    idx = '{CFG_RUN_MODE, CFG_BEATS_PER_BAR, CFG_BEAT_UNIT, CFG_CHANNEL,
            CFG_ACCENT_CLICK, CFG_REGULAR_CLICK, CFG_LEAD_BARS};
    val = '{CFG_DATA_W'(run), CFG_DATA_W'(bpb), CFG_DATA_W'(unit), CFG_DATA_W'(chan),
            acc, reg_snd, CFG_DATA_W'(bars)};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int                 directed_items;
    int                 phase_len;
    int                 kind;
    int                 roll;
    logic [TW-1:0]      tick;
    logic [RUN_W-1:0]   run;
    logic [BPB_W-1:0]   bpb;
    logic [UNIT_W-1:0]  unit;
    logic [BARS_W-1:0]  bars;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the block is disabled and, with no lead bars set, a start begins no count-in.
    send_item(MODE_TICK, '0, 1'b1);
    send_item(MODE_START, '0, 1'b0);
    send_item(MODE_CANCEL, '1, 1'b1);
    drain();

    write_config(RUN_MIDI, 5'd4, 6'd4, 4'd0, 14'h2A55, 14'h1234, 8'd1);
    send_item(MODE_TICK, 32'd0, 1'b1);
    send_item(MODE_TICK, 32'd50, 1'b1);
    send_item(MODE_TICK, 32'd96, 1'b1);
    send_item(MODE_TICK, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_TICK, 32'd200, 1'b0);
    send_item(MODE_NONE, 32'h5A5A_A5A5, 1'b1);
    send_item(MODE_START, 32'd0, 1'b0);
    send_item(MODE_TICK, 32'd0, 1'b0);
    send_item(MODE_TICK, 32'd96, 1'b0);
    send_item(MODE_TICK, 32'd384, 1'b0);
    send_item(MODE_START, 32'd0, 1'b0);
    send_item(MODE_CANCEL, 32'd0, 1'b0);
    drain();

    // Odd run mode, zero beats per bar and the largest count-in.
    write_config(RUN_SPARE, 5'd0, UNIT_EIGHTH, 4'hF, 14'h3FFF, 14'h0000, 8'd255);
    send_item(MODE_START, 32'd0, 1'b0);
    send_item(MODE_TICK, 32'd0, 1'b0);
    send_item(MODE_TICK, 32'd48, 1'b0);
    send_item(MODE_START, 32'd0, 1'b0);
    send_item(MODE_TICK, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Beats per bar above the cap, half-note beats.
    write_config(RUN_MIDI, 5'd31, UNIT_HALF, 4'h5, 14'h0000, 14'h3FFF, 8'd2);
    send_item(MODE_TICK, 32'd0, 1'b1);
    send_item(MODE_TICK, 32'd2880, 1'b1);
    send_item(MODE_TICK, 32'd3072, 1'b1);
    drain();
    directed_items = items_sent;

    while (items_sent - directed_items < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        write_config(RUN_SPARE, 5'd31, 6'd63, 4'hF, 14'h3FFF, 14'h3FFF, 8'd255);
      end else if (roll == 1) begin
        write_config(RUN_MIDI, 5'd0, 6'd0, 4'h0, 14'h0000, 14'h0000, 8'd1);
      end else begin
        run = ($urandom_range(0, 9) < 7) ? RUN_MIDI : RUN_W'($urandom_range(0, 3));
        bpb = ($urandom_range(0, 3) == 0) ? BPB_W'($urandom_range(0, 31))
                                          : BPB_W'($urandom_range(1, 6));
        case ($urandom_range(0, 3))
          0: unit = UNIT_EIGHTH;
          1: unit = UNIT_HALF;
          2: unit = 6'd4;
          default: unit = UNIT_W'($urandom_range(0, 63));
        endcase
        case ($urandom_range(0, 9))
          0: bars = '0;
          1: bars = BARS_W'($urandom_range(0, 255));
          default: bars = BARS_W'($urandom_range(1, 2));
        endcase
        write_config(run, bpb, unit, CHAN_W'($urandom_range(0, 15)),
                     CLICK_W'($urandom), CLICK_W'($urandom), bars);
      end
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      phase_len = $urandom_range(15, 40);
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0: tick = '0;
        1: tick = $urandom;
        2: tick = 32'hFFFF_FFFF - TW'($urandom_range(0, 2000));
        default: tick = TW'($urandom_range(0, 5000));
      endcase
      if (kind >= 5) begin
        send_item(MODE_START, $urandom, 1'($urandom_range(0, 1)));
        tick = TW'($urandom_range(0, 100));
      end
      for (int n = 0; n < phase_len; n++) begin
        if (kind == 9 || $urandom_range(0, 19) == 0) begin
          send_item(MODE_W'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
        end else if (kind < 5) begin
          send_item(MODE_TICK, tick, $urandom_range(0, 9) != 0);
          tick += TW'($urandom_range(1, 120));
        end else begin
          send_item(MODE_TICK, tick, $urandom_range(0, 9) == 0);
          tick += TW'($urandom_range(20, 200));
          if (!sb.count_in && $urandom_range(0, 1) == 0) begin
            send_item(MODE_START, $urandom, 1'b0);
            tick = TW'($urandom_range(0, 100));
          end
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flush_check();
    $display("summary: %0d transactions sent, %0d results checked, %0d clicks predicted",
             items_sent, sb.results_checked, sb.clicks_seen);
    $display("summary: %0d count-ins ran out, %0d mismatches", sb.count_in_ends,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[beat_click_generator_unit.f]
hw/rtl/bcg_pkg.sv
hw/rtl/bcg_div.sv
hw/rtl/beat_click_generator_unit.sv
test/tb_beat_click_generator_unit.sv
